@@ src/rrtns_pkg.sv @@
// Shared types, constants and command/status bundles of the RRT nearest/steer block.
package rrtns_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 20;
    localparam int STEP_W     = 16;
    localparam int MAG_W      = COORD_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int D2_W       = PROD_W + 1;
    localparam int STEP2_W    = 2 * STEP_W;
    localparam int SQV_W      = D2_W + 16;
    localparam int SQRT_STEPS = (SQV_W + 1) / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int SPROD_W    = STEP_W + MAG_W;
    localparam int NUM_W      = SPROD_W + 9;
    localparam int DIV_STEPS  = NUM_W;
    localparam int Q_W        = 21;
    localparam int RAM_W      = 2 * COORD_W + IDX_W;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 20;

    localparam logic [CFG_AW-1:0] REG_STEP   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GOAL_X = 2'd1;
    localparam logic [CFG_AW-1:0] REG_GOAL_Y = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd26;

    typedef enum logic [1:0] {
        OP_ROOT   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_COMMIT = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NONE       = 2'd2,
        ST_NOT_STORED = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_STEER,
        S_STEER_MUL,
        S_SQRT,
        S_DIVX_INIT,
        S_DIVX,
        S_DIVY_INIT,
        S_DIVY,
        S_PEND,
        S_READ,
        S_G_DIFF,
        S_G_MUL,
        S_G_CMP,
        S_FINISH
    } state_t;

    typedef enum logic {
        DS_STEER = 1'b0,
        DS_GOAL  = 1'b1
    } diff_src_t;

    typedef enum logic {
        MM_SQUARE = 1'b0,
        MM_STEER  = 1'b1
    } mul_mode_t;

    typedef struct packed {
        logic      capture;
        logic      root_wr;
        logic      commit_wr;
        logic      pend_clear;
        logic      pend_set;
        logic      set_status;
        status_t   st;
        logic      idx_sel;
        logic      rd_issue;
        logic      rd_take;
        logic      scan_start;
        logic      scan_issue;
        logic      scan_run;
        logic      diff_load;
        diff_src_t dsrc;
        logic      mul_load;
        mul_mode_t mmode;
        logic      point_c;
        logic      sqrt_load;
        logic      sqrt_step;
        logic      div_load;
        logic      div_y;
        logic      div_step;
        logic      off_load;
        logic      gr_load;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic full;
        logic pend_valid;
        logic sel_oob;
        logic scan_last;
        logic pipe_busy;
        logic clip;
        logic sqrt_done;
        logic div_done;
    } stat_t;

endpackage

@@ src/rrtns_if.sv @@
// Channel interfaces: request, response and configuration write.
interface rrtns_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [19:0] coord_x;
    logic signed [19:0] coord_y;
    logic [9:0]         node_sel;

    modport source (output valid, opcode, coord_x, coord_y, node_sel, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, node_sel, output ready);
endinterface

interface rrtns_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [9:0]         near_index;
    logic [9:0]         node_index;
    logic signed [19:0] out_x;
    logic signed [19:0] out_y;
    logic               goal_reached;
    logic [10:0]        node_count;

    modport source (output valid, status, near_index, node_index, out_x, out_y,
                    goal_reached, node_count, input ready);
    modport sink   (input valid, status, near_index, node_index, out_x, out_y,
                    goal_reached, node_count, output ready);
endinterface

interface rrtns_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [19:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ src/rrtns_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rrtns_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/rrtns_dp.sv @@
// Datapath: tree memory, scan pipeline, square root, divider, goal test, result registers.
module rrtns_dp import rrtns_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic [1:0]                opcode,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic [IDX_W-1:0]          node_sel,
    input  logic                      cfg_we,
    input  logic [CFG_AW-1:0]         cfg_addr,
    input  logic [CFG_DW-1:0]         cfg_data,
    output logic [1:0]                status,
    output logic [IDX_W-1:0]          near_index,
    output logic [IDX_W-1:0]          node_index,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic                      goal_reached,
    output logic [CNT_W-1:0]          node_count
);

    // configuration
    logic [STEP_W-1:0]         step_reg;
    logic [STEP2_W-1:0]        step2_reg;
    logic signed [COORD_W-1:0] goal_x_reg, goal_y_reg;

    // captured request
    op_t                       op_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic [IDX_W-1:0]          sel_reg;

    // tree bookkeeping
    logic [CNT_W-1:0]          count_reg;
    logic                      pend_valid_reg;
    logic [IDX_W-1:0]          pend_parent_reg;
    logic signed [COORD_W-1:0] pend_x_reg, pend_y_reg;

    // scan pipeline
    logic [CNT_W-1:0]          scan_addr_reg;
    logic                      rd_v_reg, m_v_reg, p_v_reg;
    logic [IDX_W-1:0]          rd_idx_reg, m_idx_reg, p_idx_reg;
    logic signed [COORD_W-1:0] m_x_reg, m_y_reg, p_x_reg, p_y_reg;
    logic [MAG_W-1:0]          mag_a_reg, mag_b_reg;
    logic                      neg_a_reg, neg_b_reg;
    logic [PROD_W-1:0]         prod_a_reg, prod_b_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic signed [COORD_W-1:0] best_x_reg, best_y_reg;
    logic [D2_W-1:0]           best_d2_reg;

    // square root and divider
    logic [SQV_W-1:0]          sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [4:0]                sq_cnt_reg;
    logic [NUM_W-1:0]          dv_num_reg;
    logic [ROOT_W-1:0]         dv_rem_reg;
    logic [5:0]                dv_cnt_reg;

    // working result
    logic signed [COORD_W-1:0] pt_x_reg, pt_y_reg;
    status_t                   res_status_reg;
    logic [IDX_W-1:0]          res_near_reg, res_idx_reg;
    logic                      res_gr_reg;

    // output register
    status_t                   out_status_reg;
    logic [IDX_W-1:0]          out_near_reg, out_idx_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                      out_gr_reg;
    logic [CNT_W-1:0]          out_count_reg;

    // memory signals
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr, ram_raddr;
    logic [RAM_W-1:0]          ram_wdata, ram_rdata;
    logic signed [COORD_W-1:0] ram_x, ram_y;
    logic [IDX_W-1:0]          ram_par;

    // combinational helpers
    logic signed [COORD_W-1:0] da_l, da_r, db_l, db_r;
    logic signed [COORD_W:0]   da, db;
    logic [COORD_W:0]          da_abs, db_abs;
    logic                      diff_en, mul_en, mode_sq;
    logic [MAG_W-1:0]          op_a0, op_a1, op_b0, op_b1;
    logic [D2_W-1:0]           e_sum;
    logic [SQV_W:0]            sq_trial;
    logic                      sq_ge;
    logic [ROOT_W:0]           dv_r2, dv_s;
    logic                      dv_ge;
    logic [ROOT_W-1:0]         root;
    logic [NUM_W-1:0]          dv_init;
    logic [Q_W-1:0]            q;
    logic signed [COORD_W+1:0] off, base, sum;
    logic signed [COORD_W-1:0] sat;

    assign ram_x   = ram_rdata[RAM_W-1 -: COORD_W];
    assign ram_y   = ram_rdata[IDX_W +: COORD_W];
    assign ram_par = ram_rdata[IDX_W-1:0];

    // Tree memory: x, y and parent in one word
    always_comb
    begin
        ram_we    = cmd.root_wr | cmd.commit_wr;
        ram_waddr = cmd.commit_wr ? count_reg[IDX_W-1:0] : '0;
        ram_wdata = cmd.commit_wr ? {pend_x_reg, pend_y_reg, pend_parent_reg}
                                  : {cx_reg, cy_reg, {IDX_W{1'b0}}};
        ram_raddr = cmd.rd_issue ? sel_reg : scan_addr_reg[IDX_W-1:0];
    end

    rrtns_ram #(.WIDTH(RAM_W), .DEPTH(MAX_NODES)) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Difference unit: operand select, magnitude and sign
    always_comb
    begin
        if (cmd.scan_run)
        begin
            da_l = cx_reg;     da_r = ram_x;
            db_l = cy_reg;     db_r = ram_y;
        end
        else if (cmd.dsrc == DS_GOAL)
        begin
            da_l = goal_x_reg; da_r = pt_x_reg;
            db_l = goal_y_reg; db_r = pt_y_reg;
        end
        else
        begin
            da_l = cx_reg;     da_r = best_x_reg;
            db_l = cy_reg;     db_r = best_y_reg;
        end
        da      = {da_l[COORD_W-1], da_l} - {da_r[COORD_W-1], da_r};
        db      = {db_l[COORD_W-1], db_l} - {db_r[COORD_W-1], db_r};
        da_abs  = da[COORD_W] ? -da : da;
        db_abs  = db[COORD_W] ? -db : db;
        diff_en = (cmd.scan_run & rd_v_reg) | cmd.diff_load;
    end

    // Multiplier operand select
    always_comb
    begin
        mode_sq = cmd.scan_run | (cmd.mmode == MM_SQUARE);
        mul_en  = (cmd.scan_run & m_v_reg) | cmd.mul_load;
        op_a0   = mode_sq ? mag_a_reg : MAG_W'(step_reg);
        op_b0   = mode_sq ? mag_b_reg : MAG_W'(step_reg);
        op_a1   = mag_a_reg;
        op_b1   = mag_b_reg;
        e_sum   = {1'b0, prod_a_reg} + {1'b0, prod_b_reg};
    end

    // Square root step and divider step
    always_comb
    begin
        sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        sq_ge    = {1'b0, sq_v_reg} >= sq_trial;
        root     = sq_res_reg[ROOT_W-1:0];
        dv_s     = {1'b0, root};
        dv_r2    = {dv_rem_reg, dv_num_reg[NUM_W-1]};
        dv_ge    = dv_r2 >= dv_s;
        dv_init  = {(cmd.div_y ? prod_b_reg[SPROD_W-1:0] : prod_a_reg[SPROD_W-1:0]), 8'b0}
                   + NUM_W'(root[ROOT_W-1:1]);
    end

    // Apply signed offset to the nearest node and saturate
    always_comb
    begin
        q    = dv_num_reg[Q_W-1:0];
        off  = (cmd.div_y ? neg_b_reg : neg_a_reg) ? -{1'b0, q} : {1'b0, q};
        base = cmd.div_y ? (COORD_W+2)'(best_y_reg) : (COORD_W+2)'(best_x_reg);
        sum  = base + off;
        if (sum > (COORD_W+2)'(524287))
        begin
            sat = 20'sd524287;
        end
        else if (sum < -(COORD_W+2)'(524288))
        begin
            sat = -20'sd524288;
        end
        else
        begin
            sat = sum[COORD_W-1:0];
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.count_zero = count_reg == '0;
        stat.full       = count_reg >= CNT_W'(MAX_NODES);
        stat.pend_valid = pend_valid_reg;
        stat.sel_oob    = {1'b0, sel_reg} >= count_reg;
        stat.scan_last  = scan_addr_reg == count_reg - CNT_W'(1);
        stat.pipe_busy  = rd_v_reg | m_v_reg | p_v_reg;
        stat.clip       = best_d2_reg > D2_W'(step2_reg);
        stat.sqrt_done  = sq_cnt_reg == '0;
        stat.div_done   = dv_cnt_reg == '0;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            step2_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
        end
        else
        begin
            step2_reg <= STEP2_W'(step_reg) * STEP2_W'(step_reg);
            if (cfg_we && cfg_addr == REG_STEP)
            begin
                step_reg <= cfg_data[STEP_W-1:0];
            end
            if (cfg_we && cfg_addr == REG_GOAL_X)
            begin
                goal_x_reg <= cfg_data[COORD_W-1:0];
            end
            if (cfg_we && cfg_addr == REG_GOAL_Y)
            begin
                goal_y_reg <= cfg_data[COORD_W-1:0];
            end
        end
    end

    // Tree count, pending point and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            pend_parent_reg <= '0;
            pend_x_reg      <= '0;
            pend_y_reg      <= '0;
            scan_addr_reg   <= '0;
            rd_v_reg        <= 1'b0;
            m_v_reg         <= 1'b0;
            p_v_reg         <= 1'b0;
            sq_cnt_reg      <= '0;
            dv_cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.root_wr)
            begin
                count_reg      <= CNT_W'(1);
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.commit_wr)
            begin
                count_reg      <= count_reg + CNT_W'(1);
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.pend_clear)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.pend_set)
            begin
                pend_valid_reg  <= 1'b1;
                pend_parent_reg <= best_idx_reg;
                pend_x_reg      <= pt_x_reg;
                pend_y_reg      <= pt_y_reg;
            end

            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_addr_reg <= scan_addr_reg + CNT_W'(1);
            end
            rd_v_reg <= cmd.scan_issue;
            m_v_reg  <= cmd.scan_run & rd_v_reg;
            p_v_reg  <= cmd.scan_run & m_v_reg;

            if (cmd.sqrt_load)
            begin
                sq_cnt_reg <= 5'(SQRT_STEPS);
            end
            else if (cmd.sqrt_step)
            begin
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
            end

            if (cmd.div_load)
            begin
                dv_cnt_reg <= 6'(DIV_STEPS);
            end
            else if (cmd.div_step)
            begin
                dv_cnt_reg <= dv_cnt_reg - 6'd1;
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_t'(opcode);
            cx_reg  <= coord_x;
            cy_reg  <= coord_y;
            sel_reg <= node_sel;
        end

        // scan pipeline stages
        if (cmd.scan_issue)
        begin
            rd_idx_reg <= scan_addr_reg[IDX_W-1:0];
        end
        if (diff_en)
        begin
            mag_a_reg <= da_abs[MAG_W-1:0];
            mag_b_reg <= db_abs[MAG_W-1:0];
            neg_a_reg <= da[COORD_W];
            neg_b_reg <= db[COORD_W];
            m_idx_reg <= rd_idx_reg;
            m_x_reg   <= ram_x;
            m_y_reg   <= ram_y;
        end
        if (mul_en)
        begin
            prod_a_reg <= PROD_W'(op_a0) * PROD_W'(op_a1);
            prod_b_reg <= PROD_W'(op_b0) * PROD_W'(op_b1);
            p_idx_reg  <= m_idx_reg;
            p_x_reg    <= m_x_reg;
            p_y_reg    <= m_y_reg;
        end
        if (cmd.scan_run && p_v_reg && (p_idx_reg == '0 || e_sum < best_d2_reg))
        begin
            best_d2_reg  <= e_sum;
            best_idx_reg <= p_idx_reg;
            best_x_reg   <= p_x_reg;
            best_y_reg   <= p_y_reg;
        end

        // square root, one result bit per step
        if (cmd.sqrt_load)
        begin
            sq_v_reg   <= {best_d2_reg, 16'b0};
            sq_res_reg <= '0;
            sq_bit_reg <= SQV_W'(1) << (SQV_W - 1);
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_ge)
            begin
                sq_v_reg   <= sq_v_reg - sq_trial[SQV_W-1:0];
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end

        // restoring divider, one quotient bit per step
        if (cmd.div_load)
        begin
            dv_num_reg <= dv_init;
            dv_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dv_rem_reg <= dv_ge ? ROOT_W'(dv_r2 - dv_s) : dv_r2[ROOT_W-1:0];
            dv_num_reg <= {dv_num_reg[NUM_W-2:0], dv_ge};
        end

        // working result
        if (cmd.capture)
        begin
            res_status_reg <= ST_OK;
            res_near_reg   <= '0;
            res_idx_reg    <= '0;
            res_gr_reg     <= 1'b0;
            pt_x_reg       <= '0;
            pt_y_reg       <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.st;
            end
            if (cmd.idx_sel)
            begin
                res_idx_reg <= sel_reg;
            end
            if (cmd.root_wr || cmd.point_c)
            begin
                pt_x_reg <= cx_reg;
                pt_y_reg <= cy_reg;
            end
            else if (cmd.commit_wr)
            begin
                pt_x_reg     <= pend_x_reg;
                pt_y_reg     <= pend_y_reg;
                res_near_reg <= pend_parent_reg;
                res_idx_reg  <= count_reg[IDX_W-1:0];
            end
            else if (cmd.rd_take)
            begin
                pt_x_reg     <= ram_x;
                pt_y_reg     <= ram_y;
                res_near_reg <= ram_par;
            end
            else if (cmd.off_load && !cmd.div_y)
            begin
                pt_x_reg <= sat;
            end
            else if (cmd.off_load && cmd.div_y)
            begin
                pt_y_reg <= sat;
            end
            if (cmd.pend_set)
            begin
                res_near_reg <= best_idx_reg;
            end
            if (cmd.gr_load)
            begin
                res_gr_reg <= e_sum <= D2_W'(step2_reg);
            end
        end

        // output register
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_near_reg   <= res_near_reg;
            out_idx_reg    <= res_idx_reg;
            out_x_reg      <= pt_x_reg;
            out_y_reg      <= pt_y_reg;
            out_gr_reg     <= res_gr_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign status       = out_status_reg;
    assign near_index   = out_near_reg;
    assign node_index   = out_idx_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign goal_reached = out_gr_reg;
    assign node_count   = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_NODES))
        else $error("node count beyond capacity");

    a_pend_needs_tree: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> count_reg != '0)
        else $error("pending point with empty tree");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_run && p_v_reg) |-> ({1'b0, p_idx_reg} < count_reg))
        else $error("scan compared an unstored node");

endmodule

@@ src/rrtns_ctrl.sv @@
// Controller state machine: sequences decode, scan, steering, goal test and output.
module rrtns_ctrl import rrtns_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_ROOT:   state_next = S_G_DIFF;
                    OP_SAMPLE: state_next = stat.count_zero ? S_FINISH : S_SCAN;
                    OP_COMMIT: state_next = (!stat.pend_valid || stat.full) ? S_FINISH
                                                                            : S_G_DIFF;
                    OP_READ:   state_next = stat.sel_oob ? S_FINISH : S_READ;
                endcase
            end
            S_SCAN:      state_next = stat.scan_last ? S_DRAIN : S_SCAN;
            S_DRAIN:     state_next = stat.pipe_busy ? S_DRAIN : S_STEER;
            S_STEER:     state_next = stat.clip ? S_STEER_MUL : S_PEND;
            S_STEER_MUL: state_next = S_SQRT;
            S_SQRT:      state_next = stat.sqrt_done ? S_DIVX_INIT : S_SQRT;
            S_DIVX_INIT: state_next = S_DIVX;
            S_DIVX:      state_next = stat.div_done ? S_DIVY_INIT : S_DIVX;
            S_DIVY_INIT: state_next = S_DIVY;
            S_DIVY:      state_next = stat.div_done ? S_PEND : S_DIVY;
            S_PEND:      state_next = S_G_DIFF;
            S_READ:      state_next = S_G_DIFF;
            S_G_DIFF:    state_next = S_G_MUL;
            S_G_MUL:     state_next = S_G_CMP;
            S_G_CMP:     state_next = S_FINISH;
            S_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd       = '0;
        req_ready = state_reg == S_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = req_valid;
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_ROOT:
                    begin
                        cmd.root_wr = 1'b1;
                    end
                    OP_SAMPLE:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st         = ST_NOT_STORED;
                            cmd.pend_clear = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                        end
                    end
                    OP_COMMIT:
                    begin
                        if (!stat.pend_valid)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st         = ST_NONE;
                        end
                        else if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st         = ST_FULL;
                        end
                        else
                        begin
                            cmd.commit_wr = 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        cmd.idx_sel = 1'b1;
                        if (stat.sel_oob)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st         = ST_NOT_STORED;
                        end
                        else
                        begin
                            cmd.rd_issue = 1'b1;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_run   = 1'b1;
                cmd.scan_issue = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.scan_run = 1'b1;
            end
            S_STEER:
            begin
                cmd.diff_load = 1'b1;
                cmd.dsrc      = DS_STEER;
                cmd.point_c   = !stat.clip;
            end
            S_STEER_MUL:
            begin
                cmd.mul_load  = 1'b1;
                cmd.mmode     = MM_STEER;
                cmd.sqrt_load = 1'b1;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = !stat.sqrt_done;
            end
            S_DIVX_INIT:
            begin
                cmd.div_load = 1'b1;
            end
            S_DIVX:
            begin
                cmd.div_step = !stat.div_done;
                cmd.off_load = stat.div_done;
            end
            S_DIVY_INIT:
            begin
                cmd.div_load = 1'b1;
                cmd.div_y    = 1'b1;
            end
            S_DIVY:
            begin
                cmd.div_y    = 1'b1;
                cmd.div_step = !stat.div_done;
                cmd.off_load = stat.div_done;
            end
            S_PEND:
            begin
                cmd.pend_set = 1'b1;
            end
            S_READ:
            begin
                cmd.rd_take = 1'b1;
            end
            S_G_DIFF:
            begin
                cmd.diff_load = 1'b1;
                cmd.dsrc      = DS_GOAL;
            end
            S_G_MUL:
            begin
                cmd.mul_load = 1'b1;
                cmd.mmode    = MM_SQUARE;
            end
            S_G_CMP:
            begin
                cmd.gr_load = 1'b1;
            end
            S_FINISH:
            begin
                cmd.out_load = !out_valid_reg || rsp_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    a_capture_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_DECODE)
        else $error("accepted transaction not decoded");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("result overwritten before taken");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.capture)
        else $error("second transaction captured while busy");

endmodule

@@ src/rrt_tree_nearest_steer.sv @@
// Top level of the RRT tree store with nearest-node search and steering.
// Sample: the scan reads one node per cycle; when the point is clipped, a 29-step square
// root and two 45-step divides then run in turn.
// One transaction is in work at a time; the next is accepted while a result waits.
// Reset clears counts, pending point and handshakes, step_length to 26; the tree memory
// stays undefined until written and needs no clearing pass.
module rrt_tree_nearest_steer import rrtns_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    rrtns_req_if.sink         req,
    rrtns_rsp_if.source       rsp,
    rrtns_cfg_if.sink         cfg
);

    cmd_t  cmd;
    stat_t stat;
    logic  cfg_we;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid & cfg.ready;

    rrtns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rrtns_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (req.opcode),
        .coord_x      (req.coord_x),
        .coord_y      (req.coord_y),
        .node_sel     (req.node_sel),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg.addr),
        .cfg_data     (cfg.data),
        .status       (rsp.status),
        .near_index   (rsp.near_index),
        .node_index   (rsp.node_index),
        .out_x        (rsp.out_x),
        .out_y        (rsp.out_y),
        .goal_reached (rsp.goal_reached),
        .node_count   (rsp.node_count)
    );

endmodule

@@ verif/tb_rrtns_ifs.sv @@
// Testbench-side note: channel interfaces are taken from the RTL source; this file holds helpers.
package tb_rrtns_types;
    import rrtns_pkg::*;

    typedef struct {
        op_t                op;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [9:0]         sel;
    } tree_op_t;

    typedef struct {
        status_t            st;
        logic [9:0]         near;
        logic [9:0]         idx;
        logic signed [19:0] ox;
        logic signed [19:0] oy;
        logic               gr;
        logic [10:0]        cnt;
    } tree_result_t;
endpackage

@@ verif/tb_top.sv @@
// Self-checking testbench of the RRT tree store with nearest search and steering.
module tb_top;
    import rrtns_pkg::*;
    import tb_rrtns_types::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rrtns_req_if req ();
    rrtns_rsp_if rsp ();
    rrtns_cfg_if cfg ();

    rrt_tree_nearest_steer dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    always #5 clk = ~clk;

    // predictor state
    logic signed [19:0] node_x [MAX_NODES];
    logic signed [19:0] node_y [MAX_NODES];
    logic [9:0]         node_parent [MAX_NODES];
    int unsigned        tree_size;
    logic [9:0]         held_parent;
    logic signed [19:0] held_x;
    logic signed [19:0] held_y;
    bit                 held_valid;
    logic [15:0]        cur_step;
    logic signed [19:0] cur_goal_x;
    logic signed [19:0] cur_goal_y;

    tree_op_t     op_queue[$];
    tree_result_t result_queue[$];
    bit           failed = 1'b0;
    bit           stim_done = 1'b0;
    bit           hold_sender = 1'b0;
    int           send_wait = 0;
    int           recv_wait = 0;
    int           model_size;

    // Append one transaction to the pending stimulus.
    function automatic void add_op(tree_op_t t);
        op_queue = {op_queue, t};
    endfunction

    function automatic longint unsigned sq_diff(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        return d * d;
    endfunction

    function automatic bit near_goal(logic signed [19:0] px, logic signed [19:0] py);
        longint unsigned d2;
        d2 = sq_diff(cur_goal_x, px) + sq_diff(cur_goal_y, py);
        return d2 <= longint'(cur_step) * longint'(cur_step);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [19:0] clamp20(longint v);
        if (v > 524287) return 20'sh7FFFF;
        if (v < -524288) return -20'sh80000;
        return v[19:0];
    endfunction

    function automatic longint steer_delta(longint d, longint unsigned s);
        longint unsigned m, q;
        m = d < 0 ? -d : d;
        q = (longint'(cur_step) * m * 256 + s / 2) / s;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    // Apply one transaction to the predicted tree and return its result.
    function automatic tree_result_t tree_predict(tree_op_t t);
        tree_result_t r;
        int best;
        longint unsigned e, best_e, s;
        longint dx, dy;
        r = '{ST_OK, 0, 0, 0, 0, 0, 0};
        case (t.op)
            OP_ROOT: begin
                node_x[0] = t.x; node_y[0] = t.y; node_parent[0] = 0;
                tree_size = 1; held_valid = 0;
                r.ox = t.x; r.oy = t.y; r.gr = near_goal(t.x, t.y);
            end
            OP_SAMPLE: begin
                if (tree_size == 0) begin
                    r.st = ST_NOT_STORED; held_valid = 0;
                end
                else begin
                    best = 0; best_e = 0;
                    for (int j = 0; j < tree_size; j++) begin
                        e = sq_diff(t.x, node_x[j]) + sq_diff(t.y, node_y[j]);
                        if (j == 0 || e < best_e) begin best_e = e; best = j; end
                    end
                    dx = longint'(t.x) - node_x[best];
                    dy = longint'(t.y) - node_y[best];
                    if (best_e > longint'(cur_step) * longint'(cur_step)) begin
                        s = int_sqrt(best_e << 16);
                        r.ox = clamp20(longint'(node_x[best]) + steer_delta(dx, s));
                        r.oy = clamp20(longint'(node_y[best]) + steer_delta(dy, s));
                    end
                    else begin r.ox = t.x; r.oy = t.y; end
                    held_parent = best; held_x = r.ox; held_y = r.oy; held_valid = 1;
                    r.near = best; r.gr = near_goal(r.ox, r.oy);
                end
            end
            OP_COMMIT: begin
                if (!held_valid) r.st = ST_NONE;
                else if (tree_size >= MAX_NODES) r.st = ST_FULL;
                else begin
                    node_x[tree_size] = held_x; node_y[tree_size] = held_y;
                    node_parent[tree_size] = held_parent;
                    r.near = held_parent; r.idx = tree_size;
                    r.ox = held_x; r.oy = held_y; r.gr = near_goal(held_x, held_y);
                    tree_size++; held_valid = 0;
                end
            end
            default: begin
                r.idx = t.sel;
                if (t.sel >= tree_size) r.st = ST_NOT_STORED;
                else begin
                    r.near = node_parent[t.sel]; r.ox = node_x[t.sel]; r.oy = node_y[t.sel];
                    r.gr = near_goal(r.ox, r.oy);
                end
            end
        endcase
        r.cnt = tree_size;
        return r;
    endfunction

    // Build one transaction; a root also resets the stimulus-side tree size.
    function automatic tree_op_t mk(op_t op, int x, int y, int sel);
        tree_op_t t;
        t.op = op; t.x = 20'(x); t.y = 20'(y); t.sel = 10'(sel);
        if (op == OP_ROOT) model_size = 1;
        return t;
    endfunction

    function automatic int rnd20();
        return $signed(20'($urandom));
    endfunction

    function automatic int near_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // Drive request transactions.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req.valid <= 1'b0;
            send_wait <= 0;
        end
        else if (req.valid && !req.ready) begin
        end
        else if (send_wait > 0 || hold_sender) begin
            req.valid <= 1'b0;
            if (send_wait > 0) send_wait <= send_wait - 1;
        end
        else if (op_queue.size() > 0) begin
            tree_op_t t;
            tree_result_t p;
            t = op_queue.pop_front();
            p = tree_predict(t);
            result_queue = {result_queue, p};
            req.valid    <= 1'b1;
            req.opcode   <= t.op;
            req.coord_x  <= t.x;
            req.coord_y  <= t.y;
            req.node_sel <= t.sel;
            send_wait <= ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
        end
        else req.valid <= 1'b0;
    end

    // Check response transactions.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp.ready <= 1'b0;
            recv_wait <= 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, rsp.status);
                    failed <= 1'b1;
                end
                else begin
                    tree_result_t x;
                    x = result_queue.pop_front();
                    if (rsp.status !== x.st || rsp.near_index !== x.near ||
                        rsp.node_index !== x.idx || rsp.out_x !== x.ox ||
                        rsp.out_y !== x.oy || rsp.goal_reached !== x.gr ||
                        rsp.node_count !== x.cnt) begin
                        $display("%0t: mismatch expected st %0d near %0d idx %0d x %0d y %0d gr %0d cnt %0d",
                                 $time, x.st, x.near, x.idx, x.ox, x.oy, x.gr, x.cnt);
                        $display("%0t:          actual st %0d near %0d idx %0d x %0d y %0d gr %0d cnt %0d",
                                 $time, rsp.status, rsp.near_index, rsp.node_index,
                                 rsp.out_x, rsp.out_y, rsp.goal_reached, rsp.node_count);
                        failed <= 1'b1;
                    end
                end
                recv_wait <= ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
                rsp.ready <= 1'b0;
            end
            else if (recv_wait > 0) recv_wait <= recv_wait - 1;
            else rsp.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [1:0] a, int v);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.addr  <= a;
        cfg.data  <= v[19:0];
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (a)
            REG_STEP:   cur_step = v[15:0];
            REG_GOAL_X: cur_goal_x = v[19:0];
            REG_GOAL_Y: cur_goal_y = v[19:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (op_queue.size() > 0 || result_queue.size() > 0 || req.valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Queue a grow phase: root, then sample/commit pairs with occasional reads and noise.
    task automatic grow_phase(int n, int span);
        int k;
        add_op(mk(OP_ROOT, near_coord(span), near_coord(span), 0));
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0: add_op(mk(OP_READ, 0, 0, $urandom_range(model_size)));
                1: add_op(mk(OP_COMMIT, 0, 0, 0));
                2: add_op(mk(OP_SAMPLE, rnd20(), rnd20(), 0));
                default: begin
                    add_op(mk(OP_SAMPLE, near_coord(span), near_coord(span),
                              $urandom_range(1023)));
                    if ($urandom_range(4) != 0) begin
                        add_op(mk(OP_COMMIT, rnd20(), rnd20(), 0));
                        model_size++;
                    end
                end
            endcase
        end
        add_op(mk(OP_READ, 0, 0, $urandom_range(model_size - 1)));
    endtask

    initial begin
        req.valid = 0; req.opcode = 0; req.coord_x = 0; req.coord_y = 0; req.node_sel = 0;
        rsp.ready = 0;
        cfg.valid = 0; cfg.addr = 0; cfg.data = 0;
        tree_size = 0; held_valid = 0; held_parent = 0; held_x = 0; held_y = 0;
        cur_step = STEP_RESET; cur_goal_x = 0; cur_goal_y = 0; model_size = 0;
        repeat (9) @(posedge clk);
        rst_n = 1'b1;

        // directed: empty tree cases, extremes, steering, goal and wide register writes
        add_op(mk(OP_SAMPLE, 5, 5, 0));
        add_op(mk(OP_COMMIT, 0, 0, 0));
        add_op(mk(OP_READ, 0, 0, 0));
        add_op(mk(OP_ROOT, 0, 0, 0));
        add_op(mk(OP_SAMPLE, 10, -10, 0));
        add_op(mk(OP_COMMIT, 0, 0, 0));
        add_op(mk(OP_COMMIT, 0, 0, 0));
        add_op(mk(OP_SAMPLE, 524287, 524287, 0));
        add_op(mk(OP_COMMIT, 0, 0, 0));
        add_op(mk(OP_SAMPLE, -524288, -524288, 1023));
        add_op(mk(OP_COMMIT, 0, 0, 0));
        add_op(mk(OP_SAMPLE, -5, 5, 0));
        add_op(mk(OP_READ, 0, 0, 1));
        add_op(mk(OP_READ, 0, 0, 3));
        add_op(mk(OP_READ, 0, 0, 4));
        add_op(mk(OP_READ, 0, 0, 1023));
        add_op(mk(OP_ROOT, 524287, -524288, 0));
        add_op(mk(OP_SAMPLE, -524288, 524287, 0));
        drain();

        // with nothing outstanding after the drain, vary registers
        write_reg(REG_STEP, 20'hFFFFF);
        write_reg(REG_GOAL_X, 20'h80000);
        write_reg(REG_GOAL_Y, 20'h7FFFF);
        write_reg(2'd3, 20'h12345);
        add_op(mk(OP_ROOT, -524288, 524287, 0));
        add_op(mk(OP_SAMPLE, 524287, -524288, 0));
        add_op(mk(OP_COMMIT, 0, 0, 0));
        add_op(mk(OP_READ, 0, 0, 1));
        drain();
        write_reg(REG_STEP, 0);
        write_reg(REG_GOAL_X, 0);
        write_reg(REG_GOAL_Y, 0);
        add_op(mk(OP_ROOT, 1, 1, 0));
        add_op(mk(OP_SAMPLE, 1, 1, 0));
        add_op(mk(OP_SAMPLE, 300, -2, 0));
        add_op(mk(OP_COMMIT, 0, 0, 0));
        drain();

        // random phases with several register settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_STEP, (ph == 5) ? 65535 : $urandom_range(ph * 3000 + 1, 1));
            write_reg(REG_GOAL_X, near_coord(2000));
            write_reg(REG_GOAL_Y, near_coord(2000));
            grow_phase(32, (ph == 4) ? 524287 : 3000);
            drain();
        end

        // grow a long chain for deep scans, then probe its end
        write_reg(REG_STEP, 256);
        add_op(mk(OP_ROOT, 0, 0, 0));
        for (int k = 1; k < 100; k++) begin
            add_op(mk(OP_SAMPLE, k * 512, $urandom_range(3) - 1, 0));
            add_op(mk(OP_COMMIT, 0, 0, 0));
        end
        add_op(mk(OP_SAMPLE, rnd20(), rnd20(), 0));
        add_op(mk(OP_COMMIT, 0, 0, 0));
        add_op(mk(OP_READ, 0, 0, 1023));
        add_op(mk(OP_SAMPLE, -300, 4, 0));
        drain();
        stim_done = 1'b1;
    end

    initial begin
        hold_sender = 1'b0;
        wait (stim_done);
        if (!failed) $display("** rrt_tree_nearest_steer: PASSED **");
        else $display("** rrt_tree_nearest_steer: FAILED **");
        $finish;
    end

    initial begin
        #60000000;
        $display("** rrt_tree_nearest_steer: FAILED **");
        $finish;
    end
endmodule

@@ sim.f @@
src/rrtns_pkg.sv
src/rrtns_if.sv
src/rrtns_ram.sv
src/rrtns_dp.sv
src/rrtns_ctrl.sv
src/rrt_tree_nearest_steer.sv
verif/tb_rrtns_ifs.sv
verif/tb_top.sv
